>>> rtl/core/hva_pkg.sv
// Shared types and constants of the hard voxel assign unit.
// Depends on nothing; imported by every module of the block.
package hva_pkg;

    // Grid geometry (cells per axis as powers of two)
    localparam int unsigned GRID_X_LOG2 = 8;
    localparam int unsigned GRID_Y_LOG2 = 8;
    localparam int unsigned GRID_Z_LOG2 = 2;
    localparam int unsigned CELL_AW     = GRID_X_LOG2 + GRID_Y_LOG2 + GRID_Z_LOG2;
    localparam int unsigned AXIS_LOG [3] = '{GRID_X_LOG2, GRID_Y_LOG2, GRID_Z_LOG2};

    // Quotient bits produced by the dividers: one per cycle
    localparam int unsigned DIV_STEPS = 8;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam int unsigned MAX_VOXELS = 16384;
    localparam int unsigned MAX_POINTS = 32;
    localparam int unsigned VOXEL_AW   = $clog2(MAX_VOXELS);
    localparam int unsigned OPEN_W     = VOXEL_AW + 1;
    localparam int unsigned FILL_W     = $clog2(MAX_POINTS) + 1;

    localparam int unsigned POS_W  = 20;
    localparam int unsigned STEP_W = 16;
    localparam int unsigned REFL_W = 16;
    localparam int unsigned CFG_W  = 20;
    localparam int unsigned DVS_W  = STEP_W + DIV_STEPS - 1;
    localparam int unsigned BND_W  = STEP_W + DIV_STEPS;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_STEP_X    = 3'd3,
        CFG_STEP_Y    = 3'd4,
        CFG_STEP_Z    = 3'd5,
        CFG_PT_LIMIT  = 3'd6,
        CFG_VOX_LIMIT = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OUT_RANGE = 3'd0,
        ST_NEW_VOXEL = 3'd1,
        ST_ADDED     = 3'd2,
        ST_FULL      = 3'd3,
        ST_LIMIT     = 3'd4
    } t_hva_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CELL,
        S_VOXEL,
        S_COMMIT
    } t_hva_state;

    typedef struct packed {
        logic                    frame_start;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [REFL_W-1:0]       reflectance;
    } t_hva_in;

    typedef struct packed {
        logic [2:0]              status;
        logic [13:0]             voxel_num;
        logic [4:0]              slot;
        logic [7:0]              cell_x;
        logic [7:0]              cell_y;
        logic [1:0]              cell_z;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic [REFL_W-1:0]       out_reflectance;
    } t_hva_out;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
        logic reject;
    } t_hva_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic in_range;
    } t_hva_sts;

endpackage

>>> rtl/core/hva_ctrl.sv
// Sequencing controller of the hard voxel assign unit.
// Depends on hva_pkg; drives the command struct of hva_dp.
module hva_ctrl import hva_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_hva_sts i_sts,
    output t_hva_cmd o_cmd
);

    t_hva_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    if (i_sts.in_range) begin
                        n_state = S_CELL;
                    end else begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_CELL:  n_state = S_VOXEL;
            S_VOXEL: n_state = S_COMMIT;
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // An accepted transaction makes the block busy; busy is decoded from the registered state
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start");

    // Commit and reject are mutually exclusive and never with load
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.commit, o_cmd.reject}))
        else $error("conflicting commands");

    // Commit follows the voxel lookup state
    a_commit_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> $past(r_state) == S_VOXEL)
        else $error("commit out of sequence");
`endif

endmodule

>>> rtl/core/hva_dp.sv
// Datapath of the hard voxel assign unit: configuration, dividers,
// cell and voxel tables, result register. Depends on hva_pkg.
module hva_dp import hva_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_hva_in           i_item,
    input  t_hva_cmd          i_cmd,
    output t_hva_sts          o_sts,
    output logic              o_strobe,
    output t_hva_out          o_result
);

    // Configuration registers
    logic signed [POS_W-1:0] r_org [3];
    logic [STEP_W-1:0]       r_step [3];
    logic [5:0]              r_pt_lim;
    logic [14:0]             r_vox_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_step[0] <= STEP_W'(256);
            r_step[1] <= STEP_W'(256);
            r_step[2] <= STEP_W'(256);
            r_pt_lim  <= 6'd32;
            r_vox_lim <= 15'd16384;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:  r_org[0]  <= i_cfg_data[POS_W-1:0];
                CFG_ORIGIN_Y:  r_org[1]  <= i_cfg_data[POS_W-1:0];
                CFG_ORIGIN_Z:  r_org[2]  <= i_cfg_data[POS_W-1:0];
                CFG_STEP_X:    r_step[0] <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:    r_step[1] <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Z:    r_step[2] <= i_cfg_data[STEP_W-1:0];
                CFG_PT_LIMIT:  r_pt_lim  <= i_cfg_data[5:0];
                CFG_VOX_LIMIT: r_vox_lim <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Offset from origin and range check per axis
    logic signed [POS_W-1:0] w_pos [3];
    logic [POS_W:0]          w_d   [3];
    logic [2:0]              w_ok;

    assign w_pos[0] = i_item.pos_x;
    assign w_pos[1] = i_item.pos_y;
    assign w_pos[2] = i_item.pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_d[a]  = {w_pos[a][POS_W-1], w_pos[a]} - {r_org[a][POS_W-1], r_org[a]};
            w_ok[a] = !w_d[a][POS_W] && (r_step[a] != '0) &&
                      (BND_W'(w_d[a][POS_W-1:0]) < (BND_W'(r_step[a]) << AXIS_LOG[a]));
        end
    end

    // Restoring dividers, one quotient bit per axis per cycle
    t_hva_in              r_in;
    logic                 r_inr;
    logic [POS_W-1:0]     r_rem [3];
    logic [DVS_W-1:0]     r_dvs [3];
    logic [DIV_STEPS-1:0] r_q   [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_item;
            r_inr <= &w_ok;
            for (int a = 0; a < 3; a++) begin
                r_rem[a] <= w_d[a][POS_W-1:0];
                r_dvs[a] <= {r_step[a], {(DIV_STEPS-1){1'b0}}};
                r_q[a]   <= '0;
            end
        end else if (i_cmd.div_step) begin
            for (int a = 0; a < 3; a++) begin
                if (DVS_W'(r_rem[a]) >= r_dvs[a]) begin
                    r_rem[a] <= r_rem[a] - r_dvs[a][POS_W-1:0];
                    r_q[a]   <= {r_q[a][DIV_STEPS-2:0], 1'b1};
                end else begin
                    r_q[a]   <= {r_q[a][DIV_STEPS-2:0], 1'b0};
                end
                r_dvs[a] <= r_dvs[a] >> 1;
            end
        end
    end

    assign o_sts.in_range = r_inr;

    logic [CELL_AW-1:0] w_cell;
    assign w_cell = {r_q[2][GRID_Z_LOG2-1:0], r_q[1][GRID_Y_LOG2-1:0],
                     r_q[0][GRID_X_LOG2-1:0]};

    // Sparse-set tables: cell to voxel, and voxel back to its cell.
    // The cell table holds two-state stale ids; any id is validated
    // against the open count and the reverse table before use.
    bit   [VOXEL_AW-1:0] mem_c2v  [2**CELL_AW];
    logic [CELL_AW-1:0]  mem_v2c  [MAX_VOXELS];
    logic [FILL_W-1:0]   mem_fill [MAX_VOXELS];
    logic [VOXEL_AW-1:0] r_c2v_q;
    logic [CELL_AW-1:0]  r_v2c_q;
    logic [FILL_W-1:0]   r_fill_q;

    logic                w_new;
    logic                w_add;
    logic [VOXEL_AW-1:0] w_new_vid;
    logic [FILL_W-1:0]   w_fill_wd;

    always_ff @(posedge i_clk) begin
        r_c2v_q <= mem_c2v[w_cell];
        if (w_new) begin
            mem_c2v[w_cell] <= w_new_vid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v2c_q <= mem_v2c[r_c2v_q];
        if (w_new) begin
            mem_v2c[w_new_vid] <= w_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_q <= mem_fill[r_c2v_q];
        if (w_new) begin
            mem_fill[w_new_vid] <= w_fill_wd;
        end else if (w_add) begin
            mem_fill[r_c2v_q] <= w_fill_wd;
        end
    end

    // Decide the outcome of a lookup
    logic [OPEN_W-1:0] r_open;
    logic [OPEN_W-1:0] w_vlim;
    logic [FILL_W-1:0] w_plim;
    logic              w_hit;
    t_hva_status       w_status;

    assign w_vlim    = (r_vox_lim > OPEN_W'(MAX_VOXELS)) ? OPEN_W'(MAX_VOXELS) : r_vox_lim;
    assign w_plim    = (r_pt_lim > FILL_W'(MAX_POINTS)) ? FILL_W'(MAX_POINTS) : r_pt_lim;
    assign w_hit     = (OPEN_W'(r_c2v_q) < r_open) && (r_v2c_q == w_cell);
    assign w_new_vid = r_open[VOXEL_AW-1:0];

    always_comb begin
        w_new     = 1'b0;
        w_add     = 1'b0;
        w_fill_wd = FILL_W'(1);
        if (!w_hit) begin
            if (r_open >= w_vlim) begin
                w_status = ST_LIMIT;
            end else begin
                w_status = ST_NEW_VOXEL;
                w_new    = i_cmd.commit;
            end
        end else if (r_fill_q < w_plim) begin
            w_status  = ST_ADDED;
            w_add     = i_cmd.commit;
            w_fill_wd = r_fill_q + 1'b1;
        end else begin
            w_status = ST_FULL;
        end
    end

    // Open voxel count: clear at frame start, advance on a new voxel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (i_cmd.load && i_item.frame_start) begin
            r_open <= '0;
        end else if (w_new) begin
            r_open <= r_open + 1'b1;
        end
    end

    // Result register
    logic     r_strobe;
    t_hva_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.commit || i_cmd.reject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit || i_cmd.reject) begin
            r_out.out_x           <= r_in.pos_x;
            r_out.out_y           <= r_in.pos_y;
            r_out.out_z           <= r_in.pos_z;
            r_out.out_reflectance <= r_in.reflectance;
            if (i_cmd.reject) begin
                r_out.status    <= ST_OUT_RANGE;
                r_out.voxel_num <= '0;
                r_out.slot      <= '0;
                r_out.cell_x    <= '0;
                r_out.cell_y    <= '0;
                r_out.cell_z    <= '0;
            end else begin
                r_out.status <= w_status;
                r_out.cell_x <= r_q[0][7:0];
                r_out.cell_y <= r_q[1][7:0];
                r_out.cell_z <= r_q[2][1:0];
                case (w_status)
                    ST_NEW_VOXEL: begin
                        r_out.voxel_num <= w_new_vid;
                        r_out.slot      <= '0;
                    end
                    ST_ADDED: begin
                        r_out.voxel_num <= r_c2v_q;
                        r_out.slot      <= r_fill_q[4:0];
                    end
                    default: begin
                        r_out.voxel_num <= '0;
                        r_out.slot      <= '0;
                    end
                endcase
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // A result is shown for a single cycle per transaction
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held");

    // The open voxel count never passes the build size
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OPEN_W'(MAX_VOXELS))
        else $error("open voxel count overflow");

    // Opening a voxel advances the count by exactly one
    a_open_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_new |=> r_open == $past(r_open) + 1'b1)
        else $error("open voxel count did not advance");
`endif

endmodule

>>> rtl/core/hard_voxel_assign_unit.sv
// Top level of the hard voxel assign unit.
// Depends on hva_pkg, hva_ctrl and hva_dp.

// Each point is taken when start is high and busy low, and its one result
// appears on o_result with o_strobe high for a single cycle; the receiver
// cannot stall it. A point in range passes through one load, eight steps of
// the per-axis restoring dividers, then a cell table read, a voxel table read
// and the commit before the strobe; one out of range ends after the divider
// steps. busy falls in the strobe cycle, so the next point may start then.
// Frame start needs no clearing pass: the cell table is checked against a
// reverse voxel-to-cell table and the open voxel count.
module hard_voxel_assign_unit import hva_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             start,
    output logic             busy,
    input  t_hva_in          i_item,
    output logic             o_strobe,
    output t_hva_out         o_result
);

    t_hva_cmd w_cmd;
    t_hva_sts w_sts;

    // Sequencer
    hva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Arithmetic, tables and result register
    hva_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

>>> dv/tb.sv
// Testbench for the hard voxel assign unit: directed cases, then random points.
// Depends on hva_pkg and hard_voxel_assign_unit; results are checked against typed
// rows or an in-bench model of the grid, the cell table and the voxel fill counters.
`timescale 1ns / 1ps

module tb;
    import hva_pkg::*;

    localparam int NCELLS     = 256 * 256 * 4;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 1700;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [2:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             start;
    logic             busy;
    t_hva_in          i_item;
    logic             o_strobe;
    t_hva_out         o_result;

    hard_voxel_assign_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // Model copy of the configuration
    logic signed [19:0] org_x, org_y, org_z;
    logic [15:0]        step_x, step_y, step_z;
    logic [5:0]         pt_limit;
    logic [14:0]        vox_limit;

    // Model copy of the voxel tables
    bit                 cell_used [NCELLS];
    logic [13:0]        cell_vid [NCELLS];
    logic [5:0]         fill_count [MAX_VOXELS];
    int unsigned        open_count;

    t_hva_out           pending_results [$];
    int                 error_count;
    int                 idle_cycles;
    int                 send_idle_pct;

    // Directed stimulus: expected result typed in only where obvious
    typedef struct {
        t_hva_in  pt;
        bit       has_exp;
        t_hva_out exp_res;
    } t_vector;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit axis_cell(input logic signed [19:0] pos,
                                     input logic signed [19:0] org,
                                     input logic [15:0] stepsz, input int cells,
                                     output int idx);
        longint d;
        longint q;
        d = longint'(pos) - longint'(org);
        idx = 0;
        if (stepsz == 0 || d < 0) return 1'b0;
        q = d / longint'(stepsz);
        if (q >= cells) return 1'b0;
        idx = int'(q);
        return 1'b1;
    endfunction

    function automatic void clear_tables();
        foreach (cell_used[k]) cell_used[k] = 1'b0;
        open_count = 0;
    endfunction

    // Place one point and return its result
    function automatic t_hva_out place_point(input t_hva_in pt);
        t_hva_out    r;
        int          ix, iy, iz, cell_idx;
        int unsigned vl, pl, n;
        bit          ok;
        r = '0;
        vl = (vox_limit > MAX_VOXELS) ? MAX_VOXELS : vox_limit;
        pl = (pt_limit > MAX_POINTS) ? MAX_POINTS : pt_limit;
        if (pt.frame_start) clear_tables();
        ok = axis_cell(pt.pos_x, org_x, step_x, 256, ix);
        if (ok) ok = axis_cell(pt.pos_y, org_y, step_y, 256, iy);
        if (ok) ok = axis_cell(pt.pos_z, org_z, step_z, 4, iz);
        r.status = ST_OUT_RANGE;
        if (ok) begin
            r.cell_x = ix[7:0];
            r.cell_y = iy[7:0];
            r.cell_z = iz[1:0];
            cell_idx = (iz * 256 + iy) * 256 + ix;
            if (!cell_used[cell_idx]) begin
                if (open_count >= vl) begin
                    r.status = ST_LIMIT;
                end else begin
                    cell_used[cell_idx] = 1'b1;
                    cell_vid[cell_idx] = open_count[13:0];
                    fill_count[open_count] = 6'd1;
                    r.voxel_num = open_count[13:0];
                    r.status = ST_NEW_VOXEL;
                    open_count++;
                end
            end else begin
                n = fill_count[cell_vid[cell_idx]];
                if (n < pl) begin
                    fill_count[cell_vid[cell_idx]] = 6'(n + 1);
                    r.status = ST_ADDED;
                    r.voxel_num = cell_vid[cell_idx];
                    r.slot = n[4:0];
                end else begin
                    r.status = ST_FULL;
                end
            end
        end
        r.out_x = pt.pos_x;
        r.out_y = pt.pos_y;
        r.out_z = pt.pos_z;
        r.out_reflectance = pt.reflectance;
        return r;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            CFG_ORIGIN_X:  org_x = val;
            CFG_ORIGIN_Y:  org_y = val;
            CFG_ORIGIN_Z:  org_z = val;
            CFG_STEP_X:    step_x = val[15:0];
            CFG_STEP_Y:    step_y = val[15:0];
            CFG_STEP_Z:    step_z = val[15:0];
            CFG_PT_LIMIT:  pt_limit = val[5:0];
            CFG_VOX_LIMIT: vox_limit = val[14:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_grid(input int ox, oy, oz, sx, sy, sz, pl, vl);
        write_reg(CFG_ORIGIN_X, ox[19:0]);
        write_reg(CFG_ORIGIN_Y, oy[19:0]);
        write_reg(CFG_ORIGIN_Z, oz[19:0]);
        write_reg(CFG_STEP_X, sx[19:0]);
        write_reg(CFG_STEP_Y, sy[19:0]);
        write_reg(CFG_STEP_Z, sz[19:0]);
        write_reg(CFG_PT_LIMIT, pl[19:0]);
        write_reg(CFG_VOX_LIMIT, vl[19:0]);
    endtask

    // Wait for every outstanding result, then let the block settle
    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Send one transaction; the result is queued when the point is taken
    task automatic send_point(input t_hva_in pt, input bit has_exp, input t_hva_out ex);
        t_hva_out pred;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_item = pt;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = place_point(pt);
        if (has_exp && pred !== ex)
            $display("%0t directed row disagrees with model: typed %h model %h",
                     $time, ex, pred);
        pending_results.push_back(has_exp ? ex : pred);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Random point aimed at the current grid most of the time
    function automatic logic signed [19:0] rand_coord(input logic signed [19:0] org,
                                                      input logic [15:0] stepsz,
                                                      input int cells, input int span);
        longint v;
        if ($urandom_range(9) == 0) return 20'($urandom);
        v = longint'(org) + longint'($urandom_range(span - 1)) * stepsz
            + $urandom_range(stepsz == 0 ? 0 : stepsz - 1);
        if ($urandom_range(19) == 0) v = longint'(org) + longint'(stepsz) * cells
                                         - $urandom_range(1);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return 20'(v);
    endfunction

    task automatic random_points(input int count, input int spanxy);
        t_hva_in pt;
        repeat (count) begin
            pt.frame_start = ($urandom_range(199) == 0);
            pt.pos_x = rand_coord(org_x, step_x, 256, spanxy);
            pt.pos_y = rand_coord(org_y, step_y, 256, spanxy);
            pt.pos_z = rand_coord(org_z, step_z, 4, 4);
            pt.reflectance = 16'($urandom);
            send_point(pt, 1'b0, '0);
        end
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_hva_out e;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, o_result);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result.status !== e.status || o_result.voxel_num !== e.voxel_num ||
                    o_result.slot !== e.slot || o_result.cell_x !== e.cell_x ||
                    o_result.cell_y !== e.cell_y || o_result.cell_z !== e.cell_z ||
                    o_result.out_x !== e.out_x || o_result.out_y !== e.out_y ||
                    o_result.out_z !== e.out_z ||
                    o_result.out_reflectance !== e.out_reflectance) begin
                    $display("%0t mismatch: expected %h actual %h", $time, e, o_result);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_vector  dir_rows [$];
        t_vector  row;
        t_hva_out ex;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ORIGIN_X;
        i_cfg_data = '0;
        start = 1'b0;
        i_item = '0;
        org_x = 0; org_y = 0; org_z = 0;
        step_x = 256; step_y = 256; step_z = 256;
        pt_limit = 32; vox_limit = 16384;
        clear_tables();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset grid, extremes of the fields
        row.has_exp = 1'b1;
        row.pt = '{1'b1, 20'sd0, 20'sd0, 20'sd0, 16'hFFFF};
        ex = '0; ex.status = ST_NEW_VOXEL; ex.out_reflectance = 16'hFFFF;
        row.exp_res = ex; dir_rows.push_back(row);
        row.pt = '{1'b0, 20'sd255, 20'sd0, 20'sd0, 16'h0000};
        ex = '0; ex.status = ST_ADDED; ex.slot = 1; ex.out_x = 20'sd255;
        row.exp_res = ex; dir_rows.push_back(row);
        row.pt = '{1'b0, -20'sd1, 20'sd0, 20'sd0, 16'h1234};
        ex = '0; ex.status = ST_OUT_RANGE; ex.out_x = -20'sd1; ex.out_reflectance = 16'h1234;
        row.exp_res = ex; dir_rows.push_back(row);
        row.pt = '{1'b0, 20'sd524287, -20'sd524288, 20'sd524287, 16'h8001};
        ex = '0; ex.status = ST_OUT_RANGE; ex.out_x = 20'sd524287;
        ex.out_y = -20'sd524288; ex.out_z = 20'sd524287; ex.out_reflectance = 16'h8001;
        row.exp_res = ex; dir_rows.push_back(row);
        row.has_exp = 1'b0;
        row.pt = '{1'b0, 20'h0FFFF, 20'h0FFFF, 20'h003FF, 16'h5555}; dir_rows.push_back(row);
        row.pt = '{1'b0, 20'h10000, 20'h00100, 20'h00000, 16'hAAAA}; dir_rows.push_back(row);
        row.pt = '{1'b0, 20'h00000, 20'h00000, 20'h00400, 16'h0001}; dir_rows.push_back(row);
        row.pt = '{1'b0, 20'h0FF00, 20'h0FF00, 20'h00300, 16'h7FFF}; dir_rows.push_back(row);
        row.pt = '{1'b1, 20'h00101, 20'h00202, 20'h00103, 16'h0F0F}; dir_rows.push_back(row);
        row.pt = '{1'b0, 20'h00101, 20'h00202, 20'h00103, 16'hF0F0}; dir_rows.push_back(row);
        foreach (dir_rows[k]) send_point(dir_rows[k].pt, dir_rows[k].has_exp, dir_rows[k].exp_res);
        drain();

        // Directed: point and voxel limits of one, zero cell size, zero limits
        set_grid(-1000, -1000, -300, 1, 1, 1, 1, 1);
        row.has_exp = 1'b0;
        row.pt = '{1'b1, -20'sd1000, -20'sd1000, -20'sd300, 16'h0}; send_point(row.pt, 0, '0);
        row.pt = '{1'b0, -20'sd1000, -20'sd1000, -20'sd300, 16'h1}; send_point(row.pt, 0, '0);
        row.pt = '{1'b0, -20'sd745, -20'sd745, -20'sd297, 16'h2}; send_point(row.pt, 0, '0);
        row.pt = '{1'b0, -20'sd744, -20'sd1000, -20'sd300, 16'h3}; send_point(row.pt, 0, '0);
        drain();
        set_grid(0, 0, 0, 0, 256, 256, 0, 0);
        row.pt = '{1'b1, 20'sd5, 20'sd5, 20'sd5, 16'h4}; send_point(row.pt, 0, '0);
        drain();
        write_reg(CFG_STEP_X, 20'd256);
        row.pt = '{1'b0, 20'sd5, 20'sd5, 20'sd5, 16'h5}; send_point(row.pt, 0, '0);
        drain();
        // Zero point limit still stores the first point
        set_grid(0, 0, 0, 256, 256, 256, 0, 16384);
        row.pt = '{1'b1, 20'sd5, 20'sd5, 20'sd5, 16'h6}; send_point(row.pt, 0, '0);
        row.pt = '{1'b0, 20'sd6, 20'sd5, 20'sd5, 16'h7}; send_point(row.pt, 0, '0);
        drain();

        // Random phases over several grids and idling patterns
        set_grid(-32768, -32768, -512, 256, 256, 256, 32, 16384);
        random_points(N_RANDOM / 5, 16);
        drain();
        send_idle_pct = 78;
        set_grid(0, 0, 0, 2, 2, 3, 3, 20);
        random_points(N_RANDOM / 5, 8);
        drain();
        send_idle_pct = 9;
        set_grid(-524288, -524288, -524288, 65535, 65535, 65535, 63, 32767);
        random_points(N_RANDOM / 5, 256);
        drain();
        send_idle_pct = 0;
        set_grid(100, -200, 7, 1, 1, 1, 2, 5000);
        random_points(N_RANDOM / 5, 40);
        drain();
        send_idle_pct = 30;
        set_grid(-1280, -1280, -20, 10, 10, 10, 5, 60);
        random_points(N_RANDOM / 5, 256);
        drain();

        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
